// ----- hdl/lmc_pkg.sv -----
// Shared types and constants for the 3x3 local maximum counter.
package lmc_pkg;

  localparam int PIX_W       = 32;
  localparam int COUNT_W     = 26;
  localparam int OUT_TDATA_W = 32;
  localparam int ROWS_W      = 16;
  localparam int COLS_W      = 11;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_ROWS = 8'd0,
    REG_FRAME_COLS = 8'd1
  } cfg_reg_t;

  // Position flags that travel with each pixel down the pipeline
  typedef struct packed {
    logic row_ge2;    // at least two rows above in this frame
    logic col_ge2;    // at least two columns to the left
    logic frame_end;  // last pixel of the frame
  } item_tag_t;

endpackage

// ----- hdl/lmc_scan.sv -----
// Frame geometry registers, raster position counters and input stage.
module lmc_scan #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 65535
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [lmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lmc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              cfg_clr,
  input  logic                              accept,
  input  logic                              en,
  input  logic [lmc_pkg::PIX_W-1:0]         pix_in,
  output logic [$clog2(MAX_COLS)-1:0]       rd_addr,
  output logic                              s1_valid,
  output logic [lmc_pkg::PIX_W-1:0]         s1_px,
  output logic [$clog2(MAX_COLS)-1:0]       s1_addr,
  output lmc_pkg::item_tag_t                s1_tag
);
  import lmc_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  logic [CW-1:0] cols_m1_r;
  logic [RW-1:0] rows_m1_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          wr_rows, wr_cols;
  logic [31:0]   rows_eff, cols_eff;
  logic          col_end, row_end;
  item_tag_t     tag_nxt;

  logic          s1_valid_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [CW-1:0] s1_addr_r;
  item_tag_t     s1_tag_r;

  // Register decode
  always_comb begin
    wr_rows = 1'b0;
    wr_cols = 1'b0;
    unique case (cfg_index)
      REG_FRAME_ROWS: wr_rows = cfg_valid;
      REG_FRAME_COLS: wr_cols = cfg_valid;
      default: ;
    endcase
  end

  assign cfg_clr = wr_rows | wr_cols;

  // Clamp written geometry: zero acts as one, cap at MAX_ROWS and MAX_COLS
  always_comb begin
    rows_eff = 32'(cfg_data[ROWS_W-1:0]);
    if (rows_eff == 32'd0) rows_eff = 32'd1;
    if (rows_eff > 32'(MAX_ROWS)) rows_eff = 32'(MAX_ROWS);
    cols_eff = 32'(cfg_data[COLS_W-1:0]);
    if (cols_eff == 32'd0) cols_eff = 32'd1;
    if (cols_eff > 32'(MAX_COLS)) cols_eff = 32'(MAX_COLS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m1_r <= RW'(2);
      cols_m1_r <= CW'(2);
    end else begin
      if (wr_rows) rows_m1_r <= RW'(rows_eff - 32'd1);
      if (wr_cols) cols_m1_r <= CW'(cols_eff - 32'd1);
    end
  end

  // Raster position
  assign col_end = (col_r == cols_m1_r);
  assign row_end = (row_r == rows_m1_r);

  always_comb begin
    col_nxt = col_end ? '0 : col_r + CW'(1);
    row_nxt = row_r;
    if (col_end) row_nxt = row_end ? '0 : row_r + RW'(1);
    tag_nxt.row_ge2   = (row_r >= RW'(2));
    tag_nxt.col_ge2   = (col_r >= CW'(2));
    tag_nxt.frame_end = col_end & row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign rd_addr = col_r;

  // Input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= pix_in;
      s1_addr_r <= col_r;
      s1_tag_r  <= tag_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_px    = s1_px_r;
  assign s1_addr  = s1_addr_r;
  assign s1_tag   = s1_tag_r;

endmodule

// ----- hdl/lmc_line_buf.sv -----
// Two line buffers holding the previous two rows, registered read.
module lmc_line_buf #(
  parameter int MAX_COLS = 1024
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_COLS)-1:0]   rd_addr,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_COLS)-1:0]   wr_addr,
  input  logic [lmc_pkg::PIX_W-1:0]     wr_px,
  output logic [lmc_pkg::PIX_W-1:0]     upper_q,
  output logic [lmc_pkg::PIX_W-1:0]     mid_q
);
  import lmc_pkg::*;

  logic [PIX_W-1:0] upper_mem  [MAX_COLS];
  logic [PIX_W-1:0] middle_mem [MAX_COLS];
  logic [PIX_W-1:0] upper_q_r, mid_q_r;

  // Read column for the accepted pixel
  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_q_r <= upper_mem[rd_addr];
      mid_q_r   <= middle_mem[rd_addr];
    end
  end

  // Roll the column up one row once its old values are captured
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= mid_q_r;
      middle_mem[wr_addr] <= wr_px;
    end
  end

  assign upper_q = upper_q_r;
  assign mid_q   = mid_q_r;

endmodule

// ----- hdl/lmc_window.sv -----
// 3x3 window shift register and strict local maximum test.
module lmc_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          s1_valid,
  input  lmc_pkg::item_tag_t            s1_tag,
  input  logic [lmc_pkg::PIX_W-1:0]     s1_px,
  input  logic [lmc_pkg::PIX_W-1:0]     upper_q,
  input  logic [lmc_pkg::PIX_W-1:0]     mid_q,
  output logic                          s2_valid,
  output lmc_pkg::item_tag_t            s2_tag,
  output logic                          peak
);
  import lmc_pkg::*;

  // win_r[row][col]: row 0 oldest, col 2 newest
  logic signed [PIX_W-1:0] win_r [3][3];
  logic                    s2_valid_r;
  item_tag_t               s2_tag_r;
  logic [8:0]              gt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid;
    end
  end

  // Shift in the new column
  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= upper_q;
      win_r[1][2] <= mid_q;
      win_r[2][2] <= s1_px;
      s2_tag_r    <= s1_tag;
    end
  end

  // Centre must beat every neighbor, signed
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (k == 4) gt[k] = 1'b1;
      else        gt[k] = (win_r[1][1] > win_r[k / 3][k % 3]);
    end
  end

  assign peak     = &gt;
  assign s2_valid = s2_valid_r;
  assign s2_tag   = s2_tag_r;

endmodule

// ----- hdl/lmc_count.sv -----
// Running peak count per frame and output register.
module lmc_count (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_clr,
  input  logic                              s2_valid,
  input  lmc_pkg::item_tag_t                s2_tag,
  input  logic                              peak,
  output logic                              stall,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lmc_pkg::COUNT_W-1:0]       out_count
);
  import lmc_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_valid_r;
  logic               hit, en;

  // Hold the pipeline only when a frame result meets a full output register
  assign stall = s2_valid & s2_tag.frame_end & out_valid_r & ~out_ready;
  assign en    = ~stall;
  assign hit   = peak & s2_tag.row_ge2 & s2_tag.col_ge2;

  always_comb begin
    count_nxt = count_r;
    if (hit && count_r != COUNT_MAX) count_nxt = count_r + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clr) begin
      count_r <= '0;
    end else if (en && s2_valid) begin
      count_r <= s2_tag.frame_end ? '0 : count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && s2_valid && s2_tag.frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid && s2_tag.frame_end) out_count_r <= count_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

endmodule

// ----- hdl/local_maximum_counter_3x3_core.sv -----
// A frame's last pixel passes the input stage, window and output registers to out_tvalid.
// Throughput: one pixel per cycle; in_tready drops only while a frame's last
// pixel waits behind an unread count. Line buffers read on transfer, write from the input stage.
// Reset (rst_n low, synchronous) clears counters, geometry (3x3) and valids;
// line buffers and window are not cleared, every entry used is rewritten first.
// Top level: streams pixels in, emits one peak count per frame.
module local_maximum_counter_3x3_core #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 65535
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lmc_pkg::PIX_W-1:0]        in_tdata,   // [31:0] pixel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lmc_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [25:0] peak_count, [31:26] zero
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lmc_pkg::*;

  localparam int CW = $clog2(MAX_COLS);

  logic             accept, en, stall, cfg_clr;
  logic [CW-1:0]    rd_addr, s1_addr;
  logic             s1_valid, s2_valid, peak;
  logic [PIX_W-1:0] s1_px, upper_q, mid_q;
  item_tag_t        s1_tag, s2_tag;
  logic [COUNT_W-1:0] out_count;

  assign en        = ~stall;
  assign in_tready = en;
  assign accept    = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  lmc_scan #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_scan (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .cfg_clr,
    .accept, .en, .pix_in(in_tdata), .rd_addr,
    .s1_valid, .s1_px, .s1_addr, .s1_tag
  );

  lmc_line_buf #(.MAX_COLS(MAX_COLS)) u_line_buf (
    .clk, .rd_en(accept), .rd_addr,
    .wr_en(en & s1_valid), .wr_addr(s1_addr), .wr_px(s1_px),
    .upper_q, .mid_q
  );

  lmc_window u_window (
    .clk, .rst_n, .en, .s1_valid, .s1_tag, .s1_px, .upper_q, .mid_q,
    .s2_valid, .s2_tag, .peak
  );

  lmc_count u_count (
    .clk, .rst_n, .cfg_clr, .s2_valid, .s2_tag, .peak, .stall,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_count
  );

  assign out_tdata = {{(OUT_TDATA_W - COUNT_W){1'b0}}, out_count};

endmodule

// ----- hdl/lmc_checker.sv -----
// Port-level checks for the local maximum counter, bound to the top level.
module lmc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lmc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import lmc_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Input never blocks while the output register is empty
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // No result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result right after reset");

  // Padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:COUNT_W] == '0)
    else $error("nonzero padding in out_tdata");

endmodule

bind local_maximum_counter_3x3_core lmc_checker u_lmc_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
